// ----- hw/rtl/tksp_pkg.sv -----
// Package for the terminal key sequence parser.
// Holds parser state codes, event codes, byte constants and the decode result type.
// No dependencies.
package tksp_pkg;

  // Parser states, one-hot
  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_UTF1  = 14'b00000000000010,
    ST_UTF2  = 14'b00000000000100,
    ST_UTF3  = 14'b00000000001000,
    ST_ESC   = 14'b00000000010000,
    ST_CSI   = 14'b00000000100000,
    ST_DCS   = 14'b00000001000000,
    ST_OSC   = 14'b00000010000000,
    ST_SOS   = 14'b00000100000000,
    ST_PM    = 14'b00001000000000,
    ST_APC   = 14'b00010000000000,
    ST_SOS_E = 14'b00100000000000,
    ST_PM_E  = 14'b01000000000000,
    ST_APC_E = 14'b10000000000000
  } state_t;

  // Event codes, as seen on the event_code port
  typedef enum logic [4:0] {
    EV_PARSING   = 5'd0,
    EV_CHAR      = 5'd1,
    EV_NEWLINE   = 5'd2,
    EV_TAB       = 5'd3,
    EV_BACKSPACE = 5'd4,
    EV_DEL       = 5'd5,
    EV_KEYPAD    = 5'd6,
    EV_ALT_B     = 5'd7,
    EV_ALT_F     = 5'd8,
    EV_HOME      = 5'd9,
    EV_END       = 5'd10,
    EV_BACK      = 5'd11,
    EV_FORWARD   = 5'd12,
    EV_DELLINE   = 5'd13,
    EV_DELWORD   = 5'd14,
    EV_DELBOL    = 5'd15,
    EV_DELEOL    = 5'd16,
    EV_SIGINT    = 5'd17,
    EV_SIGQUIT   = 5'd18,
    EV_EOL       = 5'd19,
    EV_EOT       = 5'd20,
    EV_CPR       = 5'd21,
    EV_CSI       = 5'd22,
    EV_DCS       = 5'd23,
    EV_OSC       = 5'd24,
    EV_SOS       = 5'd25,
    EV_PM        = 5'd26,
    EV_APC       = 5'd27,
    EV_UP        = 5'd28,
    EV_DOWN      = 5'd29,
    EV_RIGHT     = 5'd30,
    EV_LEFT      = 5'd31
  } event_t;

  // Control bytes
  localparam logic [7:0] B_CTRL_A    = 8'h01;
  localparam logic [7:0] B_CTRL_C    = 8'h03;
  localparam logic [7:0] B_CTRL_D    = 8'h04;
  localparam logic [7:0] B_CTRL_E    = 8'h05;
  localparam logic [7:0] B_CTRL_H    = 8'h08;
  localparam logic [7:0] B_TAB       = 8'h09;
  localparam logic [7:0] B_CTRL_K    = 8'h0B;
  localparam logic [7:0] B_CR        = 8'h0D;
  localparam logic [7:0] B_CTRL_U    = 8'h15;
  localparam logic [7:0] B_ESC       = 8'h1B;
  localparam logic [7:0] B_DEL       = 8'h7F;
  // ESC followers
  localparam logic [7:0] B_DCS_INTRO = 8'h50;
  localparam logic [7:0] B_SOS_INTRO = 8'h58;
  localparam logic [7:0] B_CSI_INTRO = 8'h5B;
  localparam logic [7:0] B_BACKSLASH = 8'h5C;
  localparam logic [7:0] B_OSC_INTRO = 8'h5D;
  localparam logic [7:0] B_PM_INTRO  = 8'h5E;
  localparam logic [7:0] B_APC_INTRO = 8'h5F;
  localparam logic [7:0] B_LOWER_B   = 8'h62;
  localparam logic [7:0] B_LOWER_F   = 8'h66;
  // Parameter bytes and CSI finals
  localparam logic [7:0] B_DIGIT_0   = 8'h30;
  localparam logic [7:0] B_DIGIT_9   = 8'h39;
  localparam logic [7:0] B_SEMICOLON = 8'h3B;
  localparam logic [7:0] B_FINAL_A   = 8'h41;
  localparam logic [7:0] B_FINAL_B   = 8'h42;
  localparam logic [7:0] B_FINAL_C   = 8'h43;
  localparam logic [7:0] B_FINAL_D   = 8'h44;
  localparam logic [7:0] B_FINAL_F   = 8'h46;
  localparam logic [7:0] B_FINAL_H   = 8'h48;
  localparam logic [7:0] B_FINAL_R   = 8'h52;
  localparam logic [7:0] B_TILDE     = 8'h7E;
  // UTF-8 lead and continuation patterns
  localparam logic [7:0] U8_MASK2    = 8'hC0;
  localparam logic [7:0] U8_CONT     = 8'h80;
  localparam logic [7:0] U8_MASK3    = 8'hE0;
  localparam logic [7:0] U8_LEAD2    = 8'hC0;
  localparam logic [7:0] U8_MASK4    = 8'hF0;
  localparam logic [7:0] U8_LEAD3    = 8'hE0;
  localparam logic [7:0] U8_MASK5    = 8'hF8;
  localparam logic [7:0] U8_LEAD4    = 8'hF0;

  // Result of decoding one byte
  typedef struct packed {
    state_t next_state;
    event_t event_code;
  } step_t;

endpackage

// ----- hw/rtl/tksp_decode.sv -----
// Combinational byte decoder: next parser state and event for one byte.
// Depends on tksp_pkg.
module tksp_decode import tksp_pkg::*; (
  input  state_t      state,
  input  logic [7:0]  in_byte,
  output step_t       step
);

  logic is_param;
  logic is_cont;

  assign is_param = ((in_byte >= B_DIGIT_0) && (in_byte <= B_DIGIT_9)) ||
                    (in_byte == B_SEMICOLON);
  assign is_cont  = (in_byte & U8_MASK2) == U8_CONT;

  always_comb begin
    step.next_state = state;
    step.event_code = EV_PARSING;
    // Ctrl-C and Ctrl-D abort from any state
    if (in_byte == B_CTRL_C) begin
      step.next_state = ST_IDLE;
      step.event_code = EV_SIGINT;
    end else if (in_byte == B_CTRL_D) begin
      step.next_state = ST_IDLE;
      step.event_code = EV_EOT;
    end else begin
      case (state)
        ST_IDLE: begin
          case (in_byte)
            B_ESC:    step.next_state = ST_ESC;
            B_CTRL_A: step.event_code = EV_HOME;
            B_CTRL_E: step.event_code = EV_END;
            B_CTRL_H: step.event_code = EV_DELLINE;
            B_TAB:    step.event_code = EV_TAB;
            B_CR:     step.event_code = EV_NEWLINE;
            B_CTRL_K: step.event_code = EV_DELEOL;
            B_CTRL_U: step.event_code = EV_DELBOL;
            B_DEL:    step.event_code = EV_BACKSPACE;
            default: begin
              if (!in_byte[7]) begin
                step.event_code = EV_CHAR;
              end else if ((in_byte & U8_MASK3) == U8_LEAD2) begin
                step.next_state = ST_UTF1;
              end else if ((in_byte & U8_MASK4) == U8_LEAD3) begin
                step.next_state = ST_UTF2;
              end else if ((in_byte & U8_MASK5) == U8_LEAD4) begin
                step.next_state = ST_UTF3;
              end
            end
          endcase
        end
        // UTF-8 continuation check; a bad byte drops back to idle
        ST_UTF1: begin
          step.next_state = ST_IDLE;
          if (is_cont) step.event_code = EV_CHAR;
        end
        ST_UTF2: step.next_state = is_cont ? ST_UTF1 : ST_IDLE;
        ST_UTF3: step.next_state = is_cont ? ST_UTF2 : ST_IDLE;
        ST_ESC: begin
          step.next_state = ST_IDLE;
          case (in_byte)
            B_CSI_INTRO: step.next_state = ST_CSI;
            B_OSC_INTRO: step.next_state = ST_OSC;
            B_DCS_INTRO: step.next_state = ST_DCS;
            B_SOS_INTRO: step.next_state = ST_SOS;
            B_PM_INTRO:  step.next_state = ST_PM;
            B_APC_INTRO: step.next_state = ST_APC;
            B_CR:        step.event_code = EV_EOL;
            B_DEL:       step.event_code = EV_DELWORD;
            B_LOWER_B:   step.event_code = EV_BACK;
            B_LOWER_F:   step.event_code = EV_FORWARD;
            default:     step.event_code = EV_CHAR;
          endcase
        end
        // CSI final byte decode
        ST_CSI: begin
          if (!is_param) begin
            step.next_state = ST_IDLE;
            case (in_byte)
              B_FINAL_A: step.event_code = EV_UP;
              B_FINAL_B: step.event_code = EV_DOWN;
              B_FINAL_C: step.event_code = EV_RIGHT;
              B_FINAL_D: step.event_code = EV_LEFT;
              B_FINAL_F: step.event_code = EV_END;
              B_FINAL_H: step.event_code = EV_HOME;
              B_FINAL_R: step.event_code = EV_CPR;
              B_TILDE:   step.event_code = EV_KEYPAD;
              default:   step.event_code = EV_CSI;
            endcase
          end
        end
        ST_OSC: begin
          if (!is_param) begin
            step.next_state = ST_IDLE;
            step.event_code = EV_OSC;
          end
        end
        ST_DCS: begin
          if (!is_param) begin
            step.next_state = ST_IDLE;
            step.event_code = EV_DCS;
          end
        end
        // String bodies wait for ESC backslash
        ST_SOS: if (in_byte == B_ESC) step.next_state = ST_SOS_E;
        ST_PM:  if (in_byte == B_ESC) step.next_state = ST_PM_E;
        ST_APC: if (in_byte == B_ESC) step.next_state = ST_APC_E;
        ST_SOS_E: begin
          if (in_byte == B_BACKSLASH) begin
            step.next_state = ST_IDLE;
            step.event_code = EV_SOS;
          end else begin
            step.next_state = ST_SOS;
          end
        end
        ST_PM_E: begin
          if (in_byte == B_BACKSLASH) begin
            step.next_state = ST_IDLE;
            step.event_code = EV_PM;
          end else begin
            step.next_state = ST_PM;
          end
        end
        ST_APC_E: begin
          if (in_byte == B_BACKSLASH) begin
            step.next_state = ST_IDLE;
            step.event_code = EV_APC;
          end else begin
            step.next_state = ST_APC;
          end
        end
        default: step.next_state = ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/terminal_key_sequence_parser.sv -----
// Terminal key sequence parser: one event code per input byte.
// Each input byte is held in the byte register, then decoded into the result register.
// Throughput one byte per cycle; only output back pressure stalls the input.
// Synchronous active-high reset empties both registers and returns the parser to idle.
// Depends on tksp_pkg and tksp_decode.
module terminal_key_sequence_parser import tksp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] event_code
);

  logic       byte_valid;
  logic [7:0] byte_q;
  state_t     state;
  step_t      step;
  logic       advance;

  // Byte moves to the result register when that register is free or draining
  assign advance  = byte_valid && (!out_valid || out_ready);
  assign in_ready = !byte_valid || advance;

  tksp_decode u_decode (
    .state   (state),
    .in_byte (byte_q),
    .step    (step)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      out_valid  <= 1'b0;
      state      <= ST_IDLE;
    end else begin
      if (in_ready) byte_valid <= in_valid;
      if (advance) begin
        state     <= step.next_state;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) byte_q <= in_byte;
    if (advance) event_code <= 5'(step.event_code);
  end

endmodule

// ----- hw/rtl/tksp_checker.sv -----
// Port-level checker for the terminal key sequence parser, bound to the top level.
// Depends on tksp_pkg and terminal_key_sequence_parser.
module tksp_checker import tksp_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] event_code
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // Input stalls only under output back pressure
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back pressure");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_code))
    else $error("stalled result changed");

  // Ctrl-C passes the byte register and surfaces as interrupt in the result register when the output drains
  a_sigint: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_byte == B_CTRL_C) ##1 out_ready
      |=> out_valid && event_code == EV_SIGINT)
    else $error("Ctrl-C transaction did not give interrupt event");

endmodule

bind terminal_key_sequence_parser tksp_checker u_tksp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_byte    (in_byte),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .event_code (event_code)
);
